FILE: design/sha256_pkg.sv
// Shared types, constants and round functions for the SHA-256 digest block.
package sha256_pkg;

  // Input transaction: one message byte, its valid flag and the end-of-message flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_t;

  // Output transaction: one word of the final hash value.
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_t;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_PAD    = 5'b00010,
    ST_ROUND  = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_OUT    = 5'b10000
  } state_t;

  localparam int unsigned NumHashWords = 8;
  localparam int unsigned SchedDepth   = 16;
  localparam logic [7:0]  PadByte      = 8'h80;
  localparam logic [5:0]  LenPos       = 6'd56;
  localparam logic [5:0]  LastPos      = 6'd63;
  localparam logic [5:0]  LastRound    = 6'd63;
  localparam logic [2:0]  LastWord     = 3'd7;

  // Initial hash value for each word.
  function automatic logic [31:0] initial_hash(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0:    v = 32'h6a09e667;
      3'd1:    v = 32'hbb67ae85;
      3'd2:    v = 32'h3c6ef372;
      3'd3:    v = 32'ha54ff53a;
      3'd4:    v = 32'h510e527f;
      3'd5:    v = 32'h9b05688c;
      3'd6:    v = 32'h1f83d9ab;
      3'd7:    v = 32'h5be0cd19;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  // Round constants.
  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] v;
    case (t)
      6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
      6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
      6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
      6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
      6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
      6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
      6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
      6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
      6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
      6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
      6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
      6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
      6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
      6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
      6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
      6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
      6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
      6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
      6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
      6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
      6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
      6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
      6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
      6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
      6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
      6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
      6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
      6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
      6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
      6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
      6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
      6'd62: v = 32'hbef9a3f7;  6'd63: v = 32'hc67178f2;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  // Compression sigma on the a register.
  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  // Compression sigma on the e register.
  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // Message schedule sigma on the word fifteen back.
  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  // Message schedule sigma on the word two back.
  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

FILE: design/sha256_message_digest.sv
// SHA-256 digest engine: byte packing, padding sequencer and one shared round unit.
//
//   Channel | Direction | Handshake          | Payload
//   in_     | input     | in_valid/in_stall  | sha256_pkg::in_t (byte, has_byte, end)
//   out_    | output    | out_valid/out_stall| sha256_pkg::out_t (word, index, last)
//
// A byte that does not complete a 64-byte block is taken without stalling the input.
// A byte that completes a block starts the 64 rounds and then the hash update.
// An end transaction pads the remaining byte positions (a whole further block
// when the length does not fit), runs one or two compressions, and then sends
// eight digest words, one per output transaction, each held while out_stall is high.
// The round unit runs one round a cycle; the input is stalled while it works.
// Reset is synchronous and returns the hash to its initial value; no clearing pass.
module sha256_message_digest (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sha256_pkg::in_t    in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output sha256_pkg::out_t   out_item
);

  sha256_pkg::state_t state_r, state_nxt;

  logic [31:0] hash_r  [sha256_pkg::NumHashWords];
  logic [31:0] hash_nxt[sha256_pkg::NumHashWords];
  logic [31:0] rr_r    [sha256_pkg::NumHashWords];
  logic [31:0] rr_nxt  [sha256_pkg::NumHashWords];
  logic [31:0] w_r     [sha256_pkg::SchedDepth];
  logic [31:0] w_nxt   [sha256_pkg::SchedDepth];

  logic [31:0] word_r, word_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [63:0] count_r, count_nxt;
  logic [63:0] len_r, len_nxt;
  logic [5:0]  t_r, t_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        padding_r, padding_nxt;
  logic        pad_first_r, pad_first_nxt;
  logic        len_active_r, len_active_nxt;

  logic        in_acc;
  logic        feed_en;
  logic [7:0]  feed_byte;
  logic [4:0]  feed_shift;
  logic        len_byte;
  logic [31:0] round_p;
  logic [31:0] round_q;
  logic [31:0] sched_new;

  assign in_stall  = (state_r != sha256_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (state_r == sha256_pkg::ST_OUT);

  // The digest word on the output comes straight from the hash registers.
  assign out_item.digest_word = hash_r[idx_r];
  assign out_item.word_index  = idx_r;
  assign out_item.last_word   = (idx_r == sha256_pkg::LastWord);

  // Padding byte select: the marker byte, then zeros, then the bit length.
  assign len_byte   = !pad_first_r && (len_active_r || (pos_r == sha256_pkg::LenPos));
  assign feed_en    = (in_acc && in_item.has_byte) || (state_r == sha256_pkg::ST_PAD);
  assign feed_byte  = (state_r == sha256_pkg::ST_IDLE) ? in_item.data_byte :
                      pad_first_r ? sha256_pkg::PadByte :
                      len_byte ? len_r[63:56] : 8'h00;
  assign feed_shift = {~pos_r[1:0], 3'b000};

  // One compression round and one schedule extension per cycle.
  assign round_p = rr_r[7] + sha256_pkg::big_sigma1(rr_r[4])
                 + ((rr_r[4] & rr_r[5]) ^ (~rr_r[4] & rr_r[6]))
                 + sha256_pkg::round_k(t_r) + w_r[0];
  assign round_q = sha256_pkg::big_sigma0(rr_r[0])
                 + ((rr_r[0] & rr_r[1]) ^ (rr_r[0] & rr_r[2]) ^ (rr_r[1] & rr_r[2]));
  assign sched_new = sha256_pkg::small_sigma1(w_r[14]) + w_r[9]
                   + sha256_pkg::small_sigma0(w_r[1]) + w_r[0];

  always_comb begin
    state_nxt      = state_r;
    hash_nxt       = hash_r;
    rr_nxt         = rr_r;
    w_nxt          = w_r;
    word_nxt       = word_r;
    pos_nxt        = pos_r;
    count_nxt      = count_r;
    len_nxt        = len_r;
    t_nxt          = t_r;
    idx_nxt        = idx_r;
    padding_nxt    = padding_r;
    pad_first_nxt  = pad_first_r;
    len_active_nxt = len_active_r;

    // Pack the next byte big-endian; a finished word enters the schedule line.
    if (feed_en) begin
      if (pos_r[1:0] == 2'd0) begin
        word_nxt = {feed_byte, 24'h0};
      end else begin
        word_nxt = word_r | ({24'h0, feed_byte} << feed_shift);
      end
      if (pos_r[1:0] == 2'd3) begin
        for (int i = 0; i < sha256_pkg::SchedDepth - 1; i++) begin
          w_nxt[i] = w_r[i + 1];
        end
        w_nxt[sha256_pkg::SchedDepth - 1] = word_nxt;
      end
      pos_nxt = pos_r + 6'd1;
    end

    case (state_r)
      sha256_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_item.has_byte) begin
            count_nxt = count_r + 64'd1;
          end
          if (in_item.end_of_message) begin
            padding_nxt   = 1'b1;
            pad_first_nxt = 1'b1;
            len_nxt       = {count_nxt[60:0], 3'b000};
          end
          if (in_item.has_byte && (pos_r == sha256_pkg::LastPos)) begin
            rr_nxt    = hash_r;
            t_nxt     = '0;
            state_nxt = sha256_pkg::ST_ROUND;
          end else if (in_item.end_of_message) begin
            state_nxt = sha256_pkg::ST_PAD;
          end
        end
      end

      sha256_pkg::ST_PAD: begin
        pad_first_nxt = 1'b0;
        if (len_byte) begin
          len_active_nxt = 1'b1;
          len_nxt        = {len_r[55:0], 8'h00};
        end
        if (pos_r == sha256_pkg::LastPos) begin
          rr_nxt    = hash_r;
          t_nxt     = '0;
          state_nxt = sha256_pkg::ST_ROUND;
        end
      end

      sha256_pkg::ST_ROUND: begin
        rr_nxt[7] = rr_r[6];
        rr_nxt[6] = rr_r[5];
        rr_nxt[5] = rr_r[4];
        rr_nxt[4] = rr_r[3] + round_p;
        rr_nxt[3] = rr_r[2];
        rr_nxt[2] = rr_r[1];
        rr_nxt[1] = rr_r[0];
        rr_nxt[0] = round_p + round_q;
        for (int i = 0; i < sha256_pkg::SchedDepth - 1; i++) begin
          w_nxt[i] = w_r[i + 1];
        end
        w_nxt[sha256_pkg::SchedDepth - 1] = sched_new;
        t_nxt = t_r + 6'd1;
        if (t_r == sha256_pkg::LastRound) begin
          state_nxt = sha256_pkg::ST_UPDATE;
        end
      end

      // Fold the working registers into the hash, then pick what comes next.
      sha256_pkg::ST_UPDATE: begin
        for (int i = 0; i < sha256_pkg::NumHashWords; i++) begin
          hash_nxt[i] = hash_r[i] + rr_r[i];
        end
        if (len_active_r) begin
          idx_nxt   = '0;
          state_nxt = sha256_pkg::ST_OUT;
        end else if (padding_r) begin
          state_nxt = sha256_pkg::ST_PAD;
        end else begin
          state_nxt = sha256_pkg::ST_IDLE;
        end
      end

      // Send the digest words and restart for the next message.
      sha256_pkg::ST_OUT: begin
        if (!out_stall) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == sha256_pkg::LastWord) begin
            for (int i = 0; i < sha256_pkg::NumHashWords; i++) begin
              hash_nxt[i] = sha256_pkg::initial_hash(3'(i));
            end
            count_nxt      = '0;
            padding_nxt    = 1'b0;
            len_active_nxt = 1'b0;
            state_nxt      = sha256_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = sha256_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state and hash words.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sha256_pkg::ST_IDLE;
      pos_r        <= '0;
      count_r      <= '0;
      t_r          <= '0;
      idx_r        <= '0;
      padding_r    <= 1'b0;
      pad_first_r  <= 1'b0;
      len_active_r <= 1'b0;
      for (int i = 0; i < sha256_pkg::NumHashWords; i++) begin
        hash_r[i] <= sha256_pkg::initial_hash(3'(i));
      end
    end else begin
      state_r      <= state_nxt;
      pos_r        <= pos_nxt;
      count_r      <= count_nxt;
      t_r          <= t_nxt;
      idx_r        <= idx_nxt;
      padding_r    <= padding_nxt;
      pad_first_r  <= pad_first_nxt;
      len_active_r <= len_active_nxt;
      hash_r       <= hash_nxt;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    rr_r   <= rr_nxt;
    w_r    <= w_nxt;
    word_r <= word_nxt;
    len_r  <= len_nxt;
  end

endmodule

FILE: design/sha256_chk.sv
// Port-level checker for the SHA-256 digest block and its bind.
module sha256_chk (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input sha256_pkg::out_t out_item
);

  // A stalled digest word stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("digest word changed while stalled");

  // No input transaction is taken while digest words are being sent.
  a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(in_valid && !in_stall))
    else $error("input accepted during digest output");

  // Digest words follow each other with rising indexes until the last one.
  a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_item.last_word |=>
      out_valid && (out_item.word_index == $past(out_item.word_index) + 3'd1))
    else $error("digest word sequence broken");

  // The last flag marks the eighth word only.
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.last_word == (out_item.word_index == 3'd7)))
    else $error("last flag on wrong word");

  // Nothing is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block busy after reset");

endmodule

bind sha256_message_digest sha256_chk u_sha256_chk (.*);

FILE: tb/sha256_message_digest_tb.sv
// Self-checking testbench for the SHA-256 byte-stream digest block.
module sha256_message_digest_tb;

  localparam int CYCLE_LIMIT   = 500_000;
  localparam int DRAIN_CYCLES  = 300;
  localparam int PHASE_ITEMS   = 75;
  localparam int REPORT_LIMIT  = 10;

  // Idling mix and first message shape for each phase.
  localparam int IDLE_TAB  [4] = '{0, 47, 0, 24};
  localparam int STALL_TAB [4] = '{0, 0, 47, 24};
  localparam int FIRST_LEN [4] = '{56, 64, 55, 63};
  localparam bit FIRST_END [4] = '{1'b0, 1'b1, 1'b1, 1'b0};

  // Standard SHA-256 round constants and starting hash.
  localparam logic [31:0] ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [31:0] START_HASH [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Tracks the message stream, computes each digest and checks the words that come out.
  class digest_checker;
    logic [31:0]      hash_acc [8];
    logic [31:0]      msg_block [16];
    logic [63:0]      byte_count;
    sha256_pkg::out_t words_due [$];
    int               errors;
    int               words_checked;
    int               messages;
    int               bytes_taken;
    int               items_taken;
    int               idle_items;

    function new();
      foreach (hash_acc[k]) hash_acc[k] = START_HASH[k];
      foreach (msg_block[k]) msg_block[k] = '0;
      byte_count = '0;
    endfunction

    function logic [31:0] rotr(logic [31:0] v, int s);
      return (v >> s) | (v << (32 - s));
    endfunction

    // One 64-round compression of the current block into the running hash.
    function void compress_block();
      logic [31:0] sched [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      int t;
      for (t = 0; t < 16; t++) sched[t] = msg_block[t];
      for (t = 16; t < 64; t++) begin
        s0 = rotr(sched[t-15], 7) ^ rotr(sched[t-15], 18) ^ (sched[t-15] >> 3);
        s1 = rotr(sched[t-2], 17) ^ rotr(sched[t-2], 19) ^ (sched[t-2] >> 10);
        sched[t] = s1 + sched[t-7] + s0 + sched[t-16];
      end
      a = hash_acc[0]; b = hash_acc[1]; c = hash_acc[2]; d = hash_acc[3];
      e = hash_acc[4]; f = hash_acc[5]; g = hash_acc[6]; h = hash_acc[7];
      for (t = 0; t < 64; t++) begin
        t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
             + ROUND_K[t] + sched[t];
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1;
        d = c; c = b; b = a; a = t1 + t2;
      end
      hash_acc[0] += a; hash_acc[1] += b; hash_acc[2] += c; hash_acc[3] += d;
      hash_acc[4] += e; hash_acc[5] += f; hash_acc[6] += g; hash_acc[7] += h;
    endfunction

    // Big-endian placement; the first byte of a word clears the rest of it.
    function void put_byte(logic [5:0] pos, logic [7:0] val);
      int sh;
      sh = 8 * (3 - int'(pos[1:0]));
      if (pos[1:0] == 2'd0) begin
        msg_block[pos[5:2]] = {val, 24'h0};
      end else begin
        msg_block[pos[5:2]] |= 32'(val) << sh;
      end
    endfunction

    // Called for every input transaction the block accepts.
    function void take_item(sha256_pkg::in_t it);
      logic [5:0]       pos;
      logic [63:0]      bit_len;
      sha256_pkg::out_t word;
      int               k;
      if (!it.has_byte && !it.end_of_message) begin
        idle_items++;
        return;
      end
      items_taken++;
      if (it.has_byte) begin
        pos = byte_count[5:0];
        put_byte(pos, it.data_byte);
        byte_count++;
        bytes_taken++;
        if (pos == sha256_pkg::LastPos) compress_block();
      end
      if (!it.end_of_message) return;

      // Padding: marker byte, zero fill, and the bit length in the last two words.
      pos = byte_count[5:0];
      put_byte(pos, sha256_pkg::PadByte);
      for (k = int'(pos[5:2]) + 1; k < 16; k++) msg_block[k] = '0;
      if (pos >= sha256_pkg::LenPos) begin
        compress_block();
        foreach (msg_block[k]) msg_block[k] = '0;
      end
      bit_len = byte_count << 3;
      msg_block[14] = bit_len[63:32];
      msg_block[15] = bit_len[31:0];
      compress_block();

      for (k = 0; k < sha256_pkg::NumHashWords; k++) begin
        word.digest_word = hash_acc[k];
        word.word_index  = 3'(k);
        word.last_word   = (3'(k) == sha256_pkg::LastWord);
        words_due.push_back(word);
      end
      foreach (hash_acc[k]) hash_acc[k] = START_HASH[k];
      byte_count = '0;
      messages++;
    endfunction

    // Called for every output transaction the block delivers.
    function void check_word(sha256_pkg::out_t got);
      sha256_pkg::out_t want;
      if (words_due.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("ERROR: unexpected digest word %h index %0d last %0b",
                   got.digest_word, got.word_index, got.last_word);
        return;
      end
      want = words_due.pop_front();
      words_checked++;
      if (got.digest_word !== want.digest_word || got.word_index !== want.word_index ||
          got.last_word !== want.last_word) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("ERROR: digest word mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                   want.digest_word, want.word_index, want.last_word,
                   got.digest_word, got.word_index, got.last_word);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  sha256_pkg::in_t  in_item   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  sha256_pkg::out_t out_item;

  int    idle_pct  = 0;
  int    stall_pct = 0;
  int    cycle_count = 0;
  digest_checker chk;

  sha256_message_digest u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped by watchdog after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: check each accepted transaction, then pick the next stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) chk.check_word(out_item);
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Offer one transaction, with random gaps before it, and wait until it is taken.
  task automatic send(sha256_pkg::in_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      in_item  <= sha256_pkg::in_t'(10'($urandom));
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chk.take_item(it);
  endtask

  // A whole message; the end flag rides on the last byte or on an empty item.
  task automatic send_message(int len, bit end_on_byte);
    sha256_pkg::in_t it;
    int              i;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(99) < 8) begin
        it = sha256_pkg::in_t'(10'($urandom));
        it.has_byte       = 1'b0;
        it.end_of_message = 1'b0;
        send(it);
      end
      it.data_byte      = 8'($urandom);
      it.has_byte       = 1'b1;
      it.end_of_message = end_on_byte && (i == len - 1);
      send(it);
    end
    if (!end_on_byte || len == 0) begin
      it.data_byte      = 8'($urandom);
      it.has_byte       = 1'b0;
      it.end_of_message = 1'b1;
      send(it);
    end
  endtask

  // Hold the input off until every digest word in flight has been delivered.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chk.words_due.size() != 0) @(posedge clk);
  endtask

  // Short messages, block-boundary lengths and some longer ones.
  function automatic int pick_length();
    int r;
    int edges [6] = '{55, 56, 57, 63, 64, 65};
    r = $urandom_range(99);
    if (r < 40) return $urandom_range(12);
    if (r < 70) return edges[$urandom_range(5)];
    return $urandom_range(140);
  endfunction

  // Stimulus sequence.
  initial begin
    int phase_start;
    int p;
    chk = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty message right after reset, ignored items, empty again.
    send('{data_byte: 8'h00, has_byte: 1'b0, end_of_message: 1'b1});
    send('{data_byte: 8'ha5, has_byte: 1'b0, end_of_message: 1'b0});
    send('{data_byte: 8'h5a, has_byte: 1'b0, end_of_message: 1'b0});
    send('{data_byte: 8'hff, has_byte: 1'b0, end_of_message: 1'b1});
    // The classic three-byte message with the end on its last byte.
    send('{data_byte: 8'h61, has_byte: 1'b1, end_of_message: 1'b0});
    send('{data_byte: 8'h62, has_byte: 1'b1, end_of_message: 1'b0});
    send('{data_byte: 8'h63, has_byte: 1'b1, end_of_message: 1'b1});
    // Byte extremes, then a separate empty end item.
    send('{data_byte: 8'h00, has_byte: 1'b1, end_of_message: 1'b0});
    send('{data_byte: 8'hff, has_byte: 1'b1, end_of_message: 1'b0});
    send('{data_byte: 8'h80, has_byte: 1'b1, end_of_message: 1'b0});
    send('{data_byte: 8'h7f, has_byte: 1'b0, end_of_message: 1'b1});
    wait_drained();

    // Random messages under each idling pattern; the first one of each phase
    // sits on a block boundary that changes how the padding falls.
    for (p = 0; p < 4; p++) begin
      idle_pct    = IDLE_TAB[p];
      stall_pct   = STALL_TAB[p];
      phase_start = chk.items_taken;
      send_message(FIRST_LEN[p], FIRST_END[p]);
      while (chk.items_taken - phase_start < PHASE_ITEMS)
        send_message(pick_length(), $urandom_range(1));
      wait_drained();
    end

    idle_pct  = 0;
    stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (chk.words_due.size() != 0) begin
      chk.errors++;
      $display("ERROR: %0d digest words never arrived", chk.words_due.size());
    end
    $display("Covered %0d messages from %0d bytes (%0d ignored items) under four idling mixes.",
             chk.messages, chk.bytes_taken, chk.idle_items);
    $display("Checked %0d digest words, %0d errors.", chk.words_checked, chk.errors);
    if (chk.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
